// File: sv/kabf_pkg.sv
// Shared types and constants for the angle/bias Kalman filter.
// Used by the top level, the shared multiplier and the divider.
package kabf_pkg;

  localparam int FRAC_COV  = 24;
  localparam int CFG_W     = 47;
  localparam int CFG_IDX_W = 8;
  localparam int OPND_W    = 50;
  localparam int RES_W     = 48;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_NOISE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd3;

  // Reset values.
  localparam logic [CFG_W-1:0] RST_ANGLE_NOISE   = 47'd16777;
  localparam logic [CFG_W-1:0] RST_GYRO_NOISE    = 47'd50332;
  localparam logic [CFG_W-1:0] RST_MEASURE_NOISE = 47'd16777216000;
  localparam logic [CFG_W-1:0] RST_SAMPLE_PERIOD = 47'd402653;
  localparam logic signed [RES_W-1:0] COV_ONE    = 48'sd16777216;

  typedef struct packed {
    logic signed [31:0] angle_sample;
    logic signed [31:0] rate_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
  } out_word_t;

  // Request to the shared multiplier: (a * b) >> 24, floored, saturated.
  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    logic                     sat32;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] result;
  } unit_rsp_t;

  // Request to the divider: (num * 2^24) / den, toward zero, saturated.
  typedef struct packed {
    logic                    start;
    logic signed [RES_W-1:0] num;
    logic signed [48:0]      den;
  } div_req_t;

  // Saturate a 50-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Saturate a 50-bit signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) begin
      sat48 = 48'sh7fffffffffff;
    end else if (v < -50'sd140737488355328) begin
      sat48 = 48'sh800000000000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

// File: sv/kabf_mul.sv
// Shared fixed-point multiplier: four 25x25 partial products, one per cycle.
// Depends on kabf_pkg for the request and response structs.
module kabf_mul
  import kabf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mul_req_t  req,
  output unit_rsp_t rsp
);

  logic [49:0]  ma_r, mb_r;
  logic         neg_r, sat32_r, busy_r, done_r;
  logic [2:0]   cnt_r;
  logic [49:0]  pp_r;
  logic [1:0]   sh_r;
  logic [99:0]  acc_r, acc_nxt;
  logic [47:0]  res_r;
  logic [24:0]  a_part, b_part;
  logic [100:0] rnd_w;
  logic [76:0]  mag_w, cap_w;
  logic [47:0]  fin_w;

  // Pick the halves for the current partial product.
  always_comb begin
    a_part = cnt_r[1] ? ma_r[49:25] : ma_r[24:0];
    b_part = cnt_r[0] ? mb_r[49:25] : mb_r[24:0];
  end

  // Add the previous partial product at its weight.
  always_comb begin
    case (sh_r)
      2'd0:    acc_nxt = acc_r + {50'd0, pp_r};
      2'd1:    acc_nxt = acc_r + {25'd0, pp_r, 25'd0};
      2'd2:    acc_nxt = acc_r + {pp_r, 50'd0};
      default: acc_nxt = acc_r;
    endcase
  end

  // Floor for a negative product is the ceiling of the magnitude, then saturate.
  always_comb begin
    rnd_w = {1'b0, acc_r} + {77'd0, (neg_r ? 24'hffffff : 24'd0)};
    mag_w = rnd_w[100:24];
    cap_w = (sat32_r ? 77'd2147483647 : 77'd140737488355327) + {76'd0, neg_r};
    if (mag_w > cap_w) begin
      if (sat32_r) begin
        fin_w = neg_r ? 48'hffff80000000 : 48'h00007fffffff;
      end else begin
        fin_w = neg_r ? 48'h800000000000 : 48'h7fffffffffff;
      end
    end else begin
      fin_w = neg_r ? (48'd0 - mag_w[47:0]) : mag_w[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= 3'd0;
        acc_r   <= 100'd0;
        neg_r   <= req.a[49] ^ req.b[49];
        sat32_r <= req.sat32;
        ma_r    <= req.a[49] ? (50'd0 - req.a) : req.a;
        mb_r    <= req.b[49] ? (50'd0 - req.b) : req.b;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r < 3'd4) begin
          pp_r <= {25'd0, a_part} * {25'd0, b_part};
          sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          acc_r <= acc_nxt;
        end
        if (cnt_r == 3'd5) begin
          res_r  <= fin_w;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// File: sv/kabf_div.sv
// Restoring divider for the Kalman gains, one quotient bit per cycle.
// Depends on kabf_pkg for the request and response structs.
module kabf_div
  import kabf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output unit_rsp_t rsp
);

  logic [71:0] dvd_r, q_r;
  logic [48:0] ud_r, rem_r;
  logic [49:0] rem_sh;
  logic        neg_r, busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [47:0] res_r, fin_w;
  logic [71:0] cap_w;
  logic [47:0] un_w;

  assign un_w   = req.num[47] ? (48'd0 - req.num) : req.num;
  assign rem_sh = {rem_r, dvd_r[71]};

  // Saturate the quotient magnitude to the signed 48-bit range.
  always_comb begin
    cap_w = 72'd140737488355327 + {71'd0, neg_r};
    if (q_r > cap_w) begin
      fin_w = neg_r ? 48'h800000000000 : 48'h7fffffffffff;
    end else begin
      fin_w = neg_r ? (48'd0 - q_r[47:0]) : q_r[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == 49'sd0) begin
          // A zero variance gives a zero gain.
          res_r  <= 48'd0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 7'd0;
          neg_r  <= req.num[47] ^ req.den[48];
          ud_r   <= req.den[48] ? (49'd0 - req.den) : req.den;
          dvd_r  <= {un_w, 24'd0};
          rem_r  <= 49'd0;
          q_r    <= 72'd0;
        end
      end else if (busy_r) begin
        if (cnt_r == 7'd72) begin
          res_r  <= fin_w;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 7'd1;
          dvd_r <= {dvd_r[70:0], 1'b0};
          if (rem_sh >= {1'b0, ud_r}) begin
            rem_r <= 49'(rem_sh - {1'b0, ud_r});
            q_r   <= {q_r[70:0], 1'b1};
          end else begin
            rem_r <= rem_sh[48:0];
            q_r   <= {q_r[70:0], 1'b0};
          end
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// File: sv/kalman_angle_bias_filter_core.sv
// Top level of the two-state angle/gyro-bias Kalman filter.
// Depends on kabf_pkg, kabf_mul and kabf_div.
//
// One word is taken at a time: after acceptance the sequencer runs ten
// products through the shared multiplier and two gain divisions through
// the bit-serial divider, which works out one quotient bit per cycle;
// in_stall is high from acceptance until the result is loaded into the
// output register. Configuration is always ready and must be written only
// while the block is idle.
module kalman_angle_bias_filter_core
  import kabf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_PRED_ANGLE, OP_PRED_AA, OP_PRED_AB, OP_PRED_BB,
    OP_GAIN_K0, OP_GAIN_K1,
    OP_CORR_AA, OP_CORR_AB, OP_CORR_BA, OP_CORR_BB,
    OP_CORR_ANGLE, OP_CORR_BIAS
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [CFG_W-1:0] angle_noise_r, gyro_noise_r, measure_noise_r, sample_period_r;
  logic signed [31:0] angle_est_r, bias_est_r, ang_r, rate_r;
  logic signed [47:0] cov_aa_r, cov_ab_r, cov_ba_r, cov_bb_r;
  logic signed [47:0] t0_r, t1_r, k0_r, k1_r;
  logic signed [32:0] err_r;
  logic signed [48:0] var_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  mul_req_t  mul_req;
  div_req_t  div_req;
  unit_rsp_t mul_rsp, div_rsp;

  logic signed [49:0] base_w, prod_w, sum_nxt, sum_ba_nxt;
  logic signed [32:0] rate_diff;
  logic               sub_w;

  kabf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign rate_diff = {rate_r[31], rate_r} - {bias_est_r[31], bias_est_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.start = (state_r == ST_MUL_GO);
    mul_req.a     = 50'sd0;
    mul_req.b     = {3'd0, sample_period_r};
    mul_req.sat32 = 1'b0;
    case (op_r)
      OP_PRED_ANGLE: begin
        mul_req.a     = {{17{rate_diff[32]}}, rate_diff};
        mul_req.sat32 = 1'b1;
      end
      OP_PRED_AA: mul_req.a = {3'd0, angle_noise_r}
                              - {{2{cov_ab_r[47]}}, cov_ab_r}
                              - {{2{cov_ba_r[47]}}, cov_ba_r};
      OP_PRED_AB: mul_req.a = 50'sd0 - {{2{cov_bb_r[47]}}, cov_bb_r};
      OP_PRED_BB: mul_req.a = {3'd0, gyro_noise_r};
      OP_CORR_AA: begin
        mul_req.a = {{2{k0_r[47]}}, k0_r};
        mul_req.b = {{2{t0_r[47]}}, t0_r};
      end
      OP_CORR_AB: begin
        mul_req.a = {{2{k0_r[47]}}, k0_r};
        mul_req.b = {{2{t1_r[47]}}, t1_r};
      end
      OP_CORR_BA: begin
        mul_req.a = {{2{k1_r[47]}}, k1_r};
        mul_req.b = {{2{t0_r[47]}}, t0_r};
      end
      OP_CORR_BB: begin
        mul_req.a = {{2{k1_r[47]}}, k1_r};
        mul_req.b = {{2{t1_r[47]}}, t1_r};
      end
      OP_CORR_ANGLE: begin
        mul_req.a     = {{2{k0_r[47]}}, k0_r};
        mul_req.b     = {{17{err_r[32]}}, err_r};
        mul_req.sat32 = 1'b1;
      end
      OP_CORR_BIAS: begin
        mul_req.a     = {{2{k1_r[47]}}, k1_r};
        mul_req.b     = {{17{err_r[32]}}, err_r};
        mul_req.sat32 = 1'b1;
      end
      default: mul_req.a = 50'sd0;
    endcase
  end

  // Divider request: both gains share the innovation variance.
  always_comb begin
    div_req.start = (state_r == ST_DIV_GO);
    div_req.num   = (op_r == OP_GAIN_K0) ? cov_aa_r : cov_ba_r;
    div_req.den   = var_r;
  end

  // Accumulate the product into the state it belongs to.
  always_comb begin
    sub_w  = 1'b0;
    base_w = 50'sd0;
    case (op_r)
      OP_PRED_ANGLE: base_w = {{18{angle_est_r[31]}}, angle_est_r};
      OP_PRED_AA:    base_w = {{2{cov_aa_r[47]}}, cov_aa_r};
      OP_PRED_AB:    base_w = {{2{cov_ab_r[47]}}, cov_ab_r};
      OP_PRED_BB:    base_w = {{2{cov_bb_r[47]}}, cov_bb_r};
      OP_CORR_AA: begin
        base_w = {{2{cov_aa_r[47]}}, cov_aa_r};
        sub_w  = 1'b1;
      end
      OP_CORR_AB: begin
        base_w = {{2{cov_ab_r[47]}}, cov_ab_r};
        sub_w  = 1'b1;
      end
      OP_CORR_BA: begin
        base_w = {{2{cov_ba_r[47]}}, cov_ba_r};
        sub_w  = 1'b1;
      end
      OP_CORR_BB: begin
        base_w = {{2{cov_bb_r[47]}}, cov_bb_r};
        sub_w  = 1'b1;
      end
      OP_CORR_ANGLE: base_w = {{18{angle_est_r[31]}}, angle_est_r};
      OP_CORR_BIAS:  base_w = {{18{bias_est_r[31]}}, bias_est_r};
      default:       base_w = 50'sd0;
    endcase
    prod_w     = {{2{mul_rsp.result[47]}}, mul_rsp.result};
    sum_nxt    = sub_w ? (base_w - prod_w) : (base_w + prod_w);
    sum_ba_nxt = {{2{cov_ba_r[47]}}, cov_ba_r} + prod_w;
  end

  // Sequencer, filter state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      op_r            <= OP_PRED_ANGLE;
      out_valid_r     <= 1'b0;
      angle_noise_r   <= RST_ANGLE_NOISE;
      gyro_noise_r    <= RST_GYRO_NOISE;
      measure_noise_r <= RST_MEASURE_NOISE;
      sample_period_r <= RST_SAMPLE_PERIOD;
      angle_est_r     <= 32'sd0;
      bias_est_r      <= 32'sd0;
      cov_aa_r        <= COV_ONE;
      cov_ab_r        <= 48'sd0;
      cov_ba_r        <= 48'sd0;
      cov_bb_r        <= COV_ONE;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ANGLE_NOISE:   angle_noise_r   <= cfg_data;
          CFG_GYRO_NOISE:    gyro_noise_r    <= cfg_data;
          CFG_MEASURE_NOISE: measure_noise_r <= cfg_data;
          CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
          default: ;
        endcase
      end
      // The done state reloads the register itself when it hands over a word.
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ang_r   <= in_word.angle_sample;
            rate_r  <= in_word.rate_sample;
            op_r    <= OP_PRED_ANGLE;
            state_r <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state_r <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_rsp.done) begin
            case (op_r)
              OP_PRED_ANGLE, OP_CORR_ANGLE: angle_est_r <= sat32(sum_nxt);
              OP_CORR_BIAS:                 bias_est_r  <= sat32(sum_nxt);
              OP_PRED_AA, OP_CORR_AA:       cov_aa_r    <= sat48(sum_nxt);
              OP_PRED_AB: begin
                cov_ab_r <= sat48(sum_nxt);
                cov_ba_r <= sat48(sum_ba_nxt);
              end
              OP_CORR_AB:             cov_ab_r <= sat48(sum_nxt);
              OP_CORR_BA:             cov_ba_r <= sat48(sum_nxt);
              OP_PRED_BB, OP_CORR_BB: cov_bb_r <= sat48(sum_nxt);
              default: ;
            endcase
            if (op_r == OP_PRED_BB) begin
              // Innovation terms use the predicted angle and covariance.
              err_r   <= {ang_r[31], ang_r} - {angle_est_r[31], angle_est_r};
              var_r   <= {2'd0, measure_noise_r} + {cov_aa_r[47], cov_aa_r};
              t0_r    <= cov_aa_r;
              t1_r    <= cov_ab_r;
              op_r    <= OP_GAIN_K0;
              state_r <= ST_DIV_GO;
            end else if (op_r == OP_CORR_BIAS) begin
              state_r <= ST_DONE;
            end else begin
              op_r    <= op_t'(op_r + 4'd1);
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (op_r == OP_GAIN_K0) begin
              k0_r    <= div_rsp.result;
              op_r    <= OP_GAIN_K1;
              state_r <= ST_DIV_GO;
            end else begin
              k1_r    <= div_rsp.result;
              op_r    <= OP_CORR_AA;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r               <= 1'b1;
            out_word_r.filtered_angle <= angle_est_r;
            out_word_r.corrected_rate <= sat32({{17{rate_diff[32]}}, rate_diff});
            state_r                   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

endmodule

// File: sv/kabf_checker.sv
// Port-level checks for the Kalman filter core, bound to the top level.
// Depends on kabf_pkg for the word types.
module kabf_checker
  import kabf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input out_word_t out_word,
  input logic      out_valid,
  input logic      out_stall
);

  // An accepted word makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was accepted");

  // A result only appears while an item is in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind kalman_angle_bias_filter_core kabf_checker u_kabf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
);
